>>> rtl/core/work_rest_cycle_timer_core_assert.svh
// Assertion macros for the work/rest cycle timer checker.
`ifndef WORK_REST_CYCLE_TIMER_CORE_ASSERT_SVH
`define WORK_REST_CYCLE_TIMER_CORE_ASSERT_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define WRCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, without reset disable (holds during reset too).
`define WRCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/wrct_pkg.sv
// Types and constants of the work/rest cycle timer.
package wrct_pkg;

    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_WORK   = 3'd1,
        MODE_SHORT  = 3'd2,
        MODE_LONG   = 3'd3,
        MODE_PAUSE  = 3'd4,
        MODE_RESET  = 3'd5,
        MODE_APAUSE = 3'd6,
        MODE_ARESET = 3'd7
    } wrct_mode_t;

    typedef enum logic [1:0] {
        REASON_NONE = 2'd0,
        REASON_IDLE = 2'd1,
        REASON_FULL = 2'd2
    } wrct_reason_t;

    localparam logic [3:0] ACT_TICK   = 4'd0;
    localparam logic [3:0] ACT_WORK   = 4'd1;
    localparam logic [3:0] ACT_SHORT  = 4'd2;
    localparam logic [3:0] ACT_LONG   = 4'd3;
    localparam logic [3:0] ACT_DELAY  = 4'd4;
    localparam logic [3:0] ACT_SKIP   = 4'd5;
    localparam logic [3:0] ACT_PAUSE  = 4'd6;
    localparam logic [3:0] ACT_RESUME = 4'd7;
    localparam logic [3:0] ACT_RESET  = 4'd8;

    // Register indexes on the config port
    localparam logic [2:0] REG_WORK_SECONDS   = 3'd0;
    localparam logic [2:0] REG_SHORT_SECONDS  = 3'd1;
    localparam logic [2:0] REG_LONG_SECONDS   = 3'd2;
    localparam logic [2:0] REG_LONG_EVERY     = 3'd3;
    localparam logic [2:0] REG_APAUSE_IDLE    = 3'd4;
    localparam logic [2:0] REG_ARESET_IDLE    = 3'd5;
    localparam logic [2:0] REG_ENABLE_BITS    = 3'd6;

    // enable_bits positions
    localparam int EN_LONG   = 0;
    localparam int EN_APAUSE = 1;
    localparam int EN_FULL   = 2;
    localparam int EN_ARESET = 3;

    localparam logic [15:0] DELAY_SECONDS = 16'd300;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;

    typedef struct packed {
        logic [15:0] work_seconds;
        logic [15:0] short_rest_seconds;
        logic [15:0] long_rest_seconds;
        logic [7:0]  long_rest_every;
        logic [15:0] auto_pause_idle_seconds;
        logic [15:0] auto_reset_idle_seconds;
        logic [3:0]  enable_bits;
    } wrct_cfg_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] idle_seconds;
        logic        fullscreen_now;
        logic        fullscreen_check_due;
    } wrct_item_t;

    typedef struct packed {
        logic         accepted;
        wrct_reason_t pause_reason;
        logic [7:0]   short_rest_count;
        logic [15:0]  elapsed_seconds;
        wrct_mode_t   status;
    } wrct_result_t;

endpackage

>>> rtl/core/wrct_cfg_regs.sv
// Configuration register file of the work/rest cycle timer.
module wrct_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [15:0]        wr_data,
    output wrct_pkg::wrct_cfg_t cfg
);
    import wrct_pkg::*;

    wrct_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WORK_SECONDS:  cfg_reg.work_seconds            <= wr_data;
                REG_SHORT_SECONDS: cfg_reg.short_rest_seconds      <= wr_data;
                REG_LONG_SECONDS:  cfg_reg.long_rest_seconds       <= wr_data;
                REG_LONG_EVERY:    cfg_reg.long_rest_every         <= wr_data[7:0];
                REG_APAUSE_IDLE:   cfg_reg.auto_pause_idle_seconds <= wr_data;
                REG_ARESET_IDLE:   cfg_reg.auto_reset_idle_seconds <= wr_data;
                REG_ENABLE_BITS:   cfg_reg.enable_bits             <= wr_data[3:0];
                default:           ; // index beyond the list: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/wrct_seq.sv
// Sequencer state registers and per-item next-state logic.
module wrct_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   commit,
    input  wrct_pkg::wrct_item_t   item,
    input  wrct_pkg::wrct_cfg_t    cfg,
    output wrct_pkg::wrct_result_t result
);
    import wrct_pkg::*;

    wrct_mode_t   mode_reg,   mode_next;
    logic [15:0]  elapsed_reg, elapsed_next;
    logic [7:0]   count_reg,  count_next;
    wrct_reason_t reason_reg, reason_next;
    logic         ok;

    logic [15:0] elapsed_inc;
    logic [7:0]  count_inc;
    logic [7:0]  count_dec;
    logic [15:0] delay_load;
    logic        en_long, en_apause, en_full, en_areset;
    logic        idle_ge_ap, idle_ge_ar;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign count_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
    assign count_dec   = (count_reg == 8'd0) ? count_reg : count_reg - 8'd1;
    assign delay_load  = (cfg.work_seconds >= DELAY_SECONDS) ?
                         cfg.work_seconds - DELAY_SECONDS : 16'd0;
    assign en_long     = cfg.enable_bits[EN_LONG];
    assign en_apause   = cfg.enable_bits[EN_APAUSE];
    assign en_full     = cfg.enable_bits[EN_FULL];
    assign en_areset   = cfg.enable_bits[EN_ARESET];
    assign idle_ge_ap  = item.idle_seconds >= cfg.auto_pause_idle_seconds;
    assign idle_ge_ar  = item.idle_seconds >= cfg.auto_reset_idle_seconds;

    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        reason_next  = reason_reg;
        ok           = 1'b0;

        unique case (item.action)
            ACT_TICK:
            begin
                ok = 1'b1;
                unique case (mode_reg)
                    MODE_WORK:
                    begin
                        priority if (en_full && item.fullscreen_check_due &&
                                     item.fullscreen_now)
                        begin
                            mode_next   = MODE_APAUSE;
                            reason_next = REASON_FULL;
                        end
                        else if (en_apause && idle_ge_ap)
                        begin
                            mode_next   = MODE_APAUSE;
                            reason_next = REASON_IDLE;
                        end
                        else if (en_areset && idle_ge_ar)
                        begin
                            mode_next    = MODE_ARESET;
                            elapsed_next = '0;
                            count_next   = '0;
                        end
                        else if (elapsed_inc >= cfg.work_seconds)
                        begin
                            elapsed_next = '0;
                            if (en_long && count_reg >= cfg.long_rest_every)
                            begin
                                mode_next  = MODE_LONG;
                                count_next = '0;
                            end
                            else
                            begin
                                mode_next  = MODE_SHORT;
                                count_next = count_inc;
                            end
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    MODE_SHORT:
                    begin
                        if (elapsed_inc >= cfg.short_rest_seconds)
                        begin
                            mode_next    = MODE_WORK;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    MODE_LONG:
                    begin
                        if (en_long && elapsed_inc >= cfg.long_rest_seconds)
                        begin
                            mode_next    = MODE_WORK;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                    MODE_APAUSE:
                    begin
                        // fullscreen pause holds while fullscreen stays on;
                        // once it drops, fall through to the idle checks
                        if (!(reason_reg == REASON_FULL && item.fullscreen_now))
                        begin
                            if (reason_reg == REASON_FULL)
                            begin
                                mode_next   = MODE_WORK;
                                reason_next = REASON_NONE;
                            end
                            priority if (en_apause && !idle_ge_ap)
                            begin
                                mode_next   = MODE_WORK;
                                reason_next = REASON_NONE;
                            end
                            else if (en_areset && idle_ge_ar)
                            begin
                                mode_next    = MODE_ARESET;
                                elapsed_next = '0;
                                count_next   = '0;
                                reason_next  = REASON_NONE;
                            end
                            else
                            begin
                            end
                        end
                    end
                    MODE_ARESET:
                    begin
                        if (en_areset && !idle_ge_ar)
                        begin
                            mode_next    = MODE_WORK;
                            elapsed_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_WORK:
            begin
                if (mode_reg == MODE_INIT || mode_reg == MODE_SHORT ||
                    mode_reg == MODE_LONG || mode_reg == MODE_RESET)
                begin
                    mode_next    = MODE_WORK;
                    elapsed_next = '0;
                    ok           = 1'b1;
                end
                else if (mode_reg == MODE_PAUSE)
                begin
                    mode_next = MODE_WORK;
                    ok        = 1'b1;
                end
            end
            ACT_SHORT:
            begin
                if (mode_reg == MODE_WORK || mode_reg == MODE_RESET)
                begin
                    mode_next    = MODE_SHORT;
                    elapsed_next = '0;
                    count_next   = count_inc;
                    ok           = 1'b1;
                end
            end
            ACT_LONG:
            begin
                if (mode_reg == MODE_WORK || mode_reg == MODE_RESET)
                begin
                    mode_next    = MODE_LONG;
                    elapsed_next = '0;
                    count_next   = '0;
                    ok           = 1'b1;
                end
            end
            ACT_DELAY:
            begin
                if (mode_reg == MODE_SHORT || mode_reg == MODE_LONG)
                begin
                    mode_next  = MODE_WORK;
                    count_next = count_dec;
                end
                elapsed_next = delay_load;
                ok           = 1'b1;
            end
            ACT_SKIP:
            begin
                if (mode_reg == MODE_SHORT || mode_reg == MODE_LONG)
                begin
                    mode_next    = MODE_WORK;
                    elapsed_next = '0;
                    ok           = 1'b1;
                end
                else if (mode_reg == MODE_WORK)
                begin
                    elapsed_next = '0;
                    count_next   = '0;
                    ok           = 1'b1;
                end
            end
            ACT_PAUSE:
            begin
                if (mode_reg == MODE_WORK)
                begin
                    mode_next = MODE_PAUSE;
                    ok        = 1'b1;
                end
            end
            ACT_RESUME:
            begin
                if (mode_reg == MODE_PAUSE)
                begin
                    mode_next = MODE_WORK;
                    ok        = 1'b1;
                end
            end
            ACT_RESET:
            begin
                if (mode_reg == MODE_WORK || mode_reg == MODE_SHORT ||
                    mode_reg == MODE_LONG || mode_reg == MODE_PAUSE)
                begin
                    mode_next    = MODE_RESET;
                    elapsed_next = '0;
                    count_next   = '0;
                    ok           = 1'b1;
                end
            end
            default: ; // unknown action: refused, no change
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_INIT;
            elapsed_reg <= '0;
            count_reg   <= '0;
            reason_reg  <= REASON_NONE;
        end
        else if (commit)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            reason_reg  <= reason_next;
        end
    end

    always_comb
    begin
        result.status           = mode_next;
        result.elapsed_seconds  = elapsed_next;
        result.short_rest_count = count_next;
        result.pause_reason     = reason_next;
        result.accepted         = ok;
    end

endmodule

>>> rtl/core/work_rest_cycle_timer_core.sv
// Top level of the work/rest cycle timer: input stage, sequencer, result register.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser action, tdata idle + fullscreen flags
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata status/elapsed/count/reason/accepted
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data (always ready)
//
//  One beat per clock sustained while m_axis is not stalled. A beat lands in the input
//  register, and in the cycle it moves on the sequencer state and the result register
//  update together, so a result reaches m_axis through the input and result registers.
//  rst_n clears the mode, counters, config registers and both valid flags.
//  A stall on m_axis holds the result; the input register still takes one beat,
//  after which s_axis_tready drops until the result is taken.
module work_rest_cycle_timer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: one tick or command per beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [15:0] idle_seconds, [16] fullscreen_now,
                                       // [17] fullscreen_check_due, [23:18] zero
    input  logic [3:0]  s_axis_tuser,  // [3:0] action
    // master stream: one result per input beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [2:0] status, [18:3] elapsed_seconds,
                                       // [26:19] short_rest_count, [28:27] pause_reason,
                                       // [29] accepted, [31:30] zero
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import wrct_pkg::*;

    wrct_cfg_t    cfg;
    wrct_item_t   item_reg;
    logic         item_valid_reg;
    wrct_result_t step_result;
    wrct_result_t result_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         in_take;

    assign cfg_ready = 1'b1;

    wrct_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Item moves from the input register into the sequencer when the
    // result register is empty or being drained this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !item_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            item_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.action               <= s_axis_tuser;
            item_reg.idle_seconds         <= s_axis_tdata[15:0];
            item_reg.fullscreen_now       <= s_axis_tdata[16];
            item_reg.fullscreen_check_due <= s_axis_tdata[17];
        end
    end

    wrct_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (item_valid_reg && advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
        begin
            result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, result_reg};

endmodule

>>> rtl/core/wrct_checker.sv
// Port-level checker for the work/rest cycle timer, bound to the top level.
`include "work_rest_cycle_timer_core_assert.svh"

module wrct_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import wrct_pkg::*;

    logic [2:0] out_status;
    logic [7:0] out_count;
    logic [1:0] out_reason;

    assign out_status = m_axis_tdata[2:0];
    assign out_count  = m_axis_tdata[26:19];
    assign out_reason = m_axis_tdata[28:27];

    // a stalled result holds
    `WRCT_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // with nothing waiting at the output the input side must be open
    `WRCT_ASSERT_ALWAYS(a_in_open, clk, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

    // a pause reason only exists in auto pause
    `WRCT_ASSERT(a_reason_mode, clk, rst_n, m_axis_tvalid && out_reason != REASON_NONE |-> out_status == MODE_APAUSE, "pause reason outside auto pause")

    // auto reset always has a cleared rest count
    `WRCT_ASSERT(a_areset_count, clk, rst_n, m_axis_tvalid && out_status == MODE_ARESET |-> out_count == 8'd0, "rest count kept in auto reset")

endmodule

bind work_rest_cycle_timer_core wrct_checker u_wrct_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the work/rest cycle timer core.
`timescale 1ns / 100ps

module tb_top;
    import wrct_pkg::*;

    // Watchdog: cycles in a row with no beat on any channel before giving up.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Cycles to let the pipeline settle after the last result.
    localparam int unsigned SETTLE_CYCLES = 4;
    // Receiver hold-off used to fill the block and stall its input.
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PHASE_ITEMS = 150;
    // Mismatch lines printed before going quiet (errors are still counted).
    localparam int unsigned MAX_REPORTS = 200;

    // Configuration flavors for the random phases.
    localparam int CFG_SMALL = 0;
    localparam int CFG_ZERO  = 1;
    localparam int CFG_MAX   = 2;
    localparam int CFG_WIDE  = 3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // [15:0] idle_seconds, [16] fullscreen_now,
                                // [17] fullscreen_check_due, [23:18] zero
    logic [3:0]  s_axis_tuser;  // [3:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // [2:0] status, [18:3] elapsed_seconds,
                                // [26:19] short_rest_count, [28:27] pause_reason,
                                // [29] accepted, [31:30] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    work_rest_cycle_timer_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer shadow: our own copy of the sequencer state and its registers.
    // ------------------------------------------------------------------
    wrct_cfg_t    tm_cfg;
    wrct_mode_t   tm_mode;
    logic [15:0]  tm_elapsed;
    logic [7:0]   tm_rests;
    wrct_reason_t tm_reason;

    // Expected result beats, oldest first.
    wrct_result_t expected_status_q[$];

    int unsigned error_count;
    bit          idling;        // random gaps on both sides when set
    int unsigned sink_hold;     // long receiver hold-off requested by a test
    int unsigned sink_stall;    // remaining cycles of the current random stall
    int unsigned quiet_cycles;

    task automatic timer_count_up();
        if (tm_elapsed != ELAPSED_MAX)
            tm_elapsed++;
    endtask

    task automatic timer_go_short();
        tm_mode    = MODE_SHORT;
        tm_elapsed = '0;
        if (tm_rests != COUNT_MAX)
            tm_rests++;
    endtask

    // Enter a mode with elapsed and the rest count both cleared (long rest,
    // skip from work, reset, auto-reset).
    task automatic timer_go_clear(input wrct_mode_t m);
        tm_mode    = m;
        tm_elapsed = '0;
        tm_rests   = '0;
    endtask

    // One-second tick: counting, period ends, idle and fullscreen handling.
    task automatic timer_tick(input wrct_item_t it);
        logic [3:0] en;
        bit         fs_hold;
        en = tm_cfg.enable_bits;
        fs_hold = 1'b0;
        case (tm_mode)
            MODE_WORK:
            begin
                if (en[EN_FULL] && it.fullscreen_check_due && it.fullscreen_now)
                begin
                    tm_mode   = MODE_APAUSE;
                    tm_reason = REASON_FULL;
                end
                else if (en[EN_APAUSE] && it.idle_seconds >= tm_cfg.auto_pause_idle_seconds)
                begin
                    tm_mode   = MODE_APAUSE;
                    tm_reason = REASON_IDLE;
                end
                else if (en[EN_ARESET] && it.idle_seconds >= tm_cfg.auto_reset_idle_seconds)
                    timer_go_clear(MODE_ARESET);
                else
                begin
                    timer_count_up();
                    if (tm_elapsed >= tm_cfg.work_seconds)
                    begin
                        if (en[EN_LONG] && tm_rests >= tm_cfg.long_rest_every)
                            timer_go_clear(MODE_LONG);
                        else
                            timer_go_short();
                    end
                end
            end
            MODE_SHORT:
            begin
                timer_count_up();
                if (tm_elapsed >= tm_cfg.short_rest_seconds)
                begin
                    tm_mode    = MODE_WORK;
                    tm_elapsed = '0;
                end
            end
            MODE_LONG:
            begin
                // with long rests disabled only a command ends this mode
                timer_count_up();
                if (en[EN_LONG] && tm_elapsed >= tm_cfg.long_rest_seconds)
                begin
                    tm_mode    = MODE_WORK;
                    tm_elapsed = '0;
                end
            end
            MODE_APAUSE:
            begin
                // fullscreen pause samples fullscreen on every tick
                if (tm_reason == REASON_FULL)
                begin
                    if (it.fullscreen_now)
                        fs_hold = 1'b1;
                    else
                    begin
                        tm_mode   = MODE_WORK;
                        tm_reason = REASON_NONE;
                    end
                end
                if (!fs_hold)
                begin
                    if (en[EN_APAUSE] && it.idle_seconds < tm_cfg.auto_pause_idle_seconds)
                    begin
                        tm_mode   = MODE_WORK;
                        tm_reason = REASON_NONE;
                    end
                    else if (en[EN_ARESET]
                             && it.idle_seconds >= tm_cfg.auto_reset_idle_seconds)
                    begin
                        timer_go_clear(MODE_ARESET);
                        tm_reason = REASON_NONE;
                    end
                end
            end
            MODE_ARESET:
            begin
                if (en[EN_ARESET] && it.idle_seconds < tm_cfg.auto_reset_idle_seconds)
                begin
                    tm_mode    = MODE_WORK;
                    tm_elapsed = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Advance the shadow by one input beat and give the result it should produce.
    task automatic timer_step(input wrct_item_t it, output wrct_result_t res);
        bit ok;
        ok = 1'b0;
        case (it.action)
            ACT_TICK:
            begin
                timer_tick(it);
                ok = 1'b1;
            end
            ACT_WORK:
            begin
                if (tm_mode inside {MODE_INIT, MODE_SHORT, MODE_LONG, MODE_RESET})
                begin
                    tm_mode    = MODE_WORK;
                    tm_elapsed = '0;
                    ok = 1'b1;
                end
                else if (tm_mode == MODE_PAUSE)
                begin
                    tm_mode = MODE_WORK;  // elapsed carries over from the pause
                    ok = 1'b1;
                end
            end
            ACT_SHORT:
            begin
                if (tm_mode inside {MODE_WORK, MODE_RESET})
                begin
                    timer_go_short();
                    ok = 1'b1;
                end
            end
            ACT_LONG:
            begin
                if (tm_mode inside {MODE_WORK, MODE_RESET})
                begin
                    timer_go_clear(MODE_LONG);
                    ok = 1'b1;
                end
            end
            ACT_DELAY:
            begin
                // always accepted; rest count holds at zero instead of wrapping
                if (tm_mode inside {MODE_SHORT, MODE_LONG})
                begin
                    tm_mode = MODE_WORK;
                    if (tm_rests != '0)
                        tm_rests--;
                end
                tm_elapsed = (tm_cfg.work_seconds >= DELAY_SECONDS)
                             ? tm_cfg.work_seconds - DELAY_SECONDS : '0;
                ok = 1'b1;
            end
            ACT_SKIP:
            begin
                if (tm_mode inside {MODE_SHORT, MODE_LONG})
                begin
                    tm_mode    = MODE_WORK;
                    tm_elapsed = '0;
                    ok = 1'b1;
                end
                else if (tm_mode == MODE_WORK)
                begin
                    timer_go_clear(MODE_WORK);
                    ok = 1'b1;
                end
            end
            ACT_PAUSE:
            begin
                if (tm_mode == MODE_WORK)
                begin
                    tm_mode = MODE_PAUSE;
                    ok = 1'b1;
                end
            end
            ACT_RESUME:
            begin
                if (tm_mode == MODE_PAUSE)
                begin
                    tm_mode = MODE_WORK;
                    ok = 1'b1;
                end
            end
            ACT_RESET:
            begin
                if (tm_mode inside {MODE_WORK, MODE_SHORT, MODE_LONG, MODE_PAUSE})
                begin
                    timer_go_clear(MODE_RESET);
                    ok = 1'b1;
                end
            end
            default:
            begin
                // unknown action codes are refused and change nothing
            end
        endcase
        res.status           = tm_mode;
        res.elapsed_seconds  = tm_elapsed;
        res.short_rest_count = tm_rests;
        res.pause_reason     = tm_reason;
        res.accepted         = ok;
    endtask

    // ------------------------------------------------------------------
    // Idle timing for both sides
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Receiver: random stalls, plus the long hold-off when a test asks for it.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else if (sink_stall != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_stall--;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                sink_stall = pick_gap();
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    wrct_result_t got_beat;
    wrct_result_t want_beat;

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_beat = wrct_result_t'(m_axis_tdata[29:0]);
            if (expected_status_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result beat with none expected, expected nothing, got %h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want_beat = expected_status_q.pop_front();
                check_field("status", want_beat.status, got_beat.status);
                check_field("elapsed_seconds", want_beat.elapsed_seconds,
                            got_beat.elapsed_seconds);
                check_field("short_rest_count", want_beat.short_rest_count,
                            got_beat.short_rest_count);
                check_field("pause_reason", want_beat.pause_reason, got_beat.pause_reason);
                check_field("accepted", want_beat.accepted, got_beat.accepted);
            end
        end
    end

    // Watchdog: no beat on any channel for too long means the block hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_status_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All called at a rising edge, all drive with NBAs.
    // ------------------------------------------------------------------

    // Offer one beat, wait for the handshake, record its expected result.
    // tvalid is left high when no gap follows so the next beat goes back to back.
    task automatic send_item(input wrct_item_t it);
        wrct_result_t res;
        int unsigned  gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {6'b0, it.fullscreen_check_due, it.fullscreen_now, it.idle_seconds};
        do
            @(posedge clk);
        while (!s_axis_tready);
        timer_step(it, res);
        expected_status_q.push_back(res);
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write; cfg_valid is lowered by the caller after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WORK_SECONDS:  tm_cfg.work_seconds            = val;
            REG_SHORT_SECONDS: tm_cfg.short_rest_seconds      = val;
            REG_LONG_SECONDS:  tm_cfg.long_rest_seconds       = val;
            REG_LONG_EVERY:    tm_cfg.long_rest_every         = val[7:0];
            REG_APAUSE_IDLE:   tm_cfg.auto_pause_idle_seconds = val;
            REG_ARESET_IDLE:   tm_cfg.auto_reset_idle_seconds = val;
            REG_ENABLE_BITS:   tm_cfg.enable_bits             = val[3:0];
            default:
            begin
            end
        endcase
    endtask

    // Only called with the block idle.
    task automatic load_config(input wrct_cfg_t c);
        write_reg(REG_WORK_SECONDS,  c.work_seconds);
        write_reg(REG_SHORT_SECONDS, c.short_rest_seconds);
        write_reg(REG_LONG_SECONDS,  c.long_rest_seconds);
        write_reg(REG_LONG_EVERY,    {8'b0, c.long_rest_every});
        write_reg(REG_APAUSE_IDLE,   c.auto_pause_idle_seconds);
        write_reg(REG_ARESET_IDLE,   c.auto_reset_idle_seconds);
        write_reg(REG_ENABLE_BITS,   {12'b0, c.enable_bits});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every expected result is in, then let the
    // pipeline settle so a following register write sees an idle block.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic wrct_item_t make_item(input logic [3:0] act, input logic [15:0] idle,
                                             input logic now, input logic due);
        wrct_item_t it;
        it.action               = act;
        it.idle_seconds         = idle;
        it.fullscreen_now       = now;
        it.fullscreen_check_due = due;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    function automatic wrct_cfg_t pick_config(input int kind);
        wrct_cfg_t c;
        case (kind)
            CFG_ZERO:
            begin
                c = '0;
                c.enable_bits = 4'hF;
            end
            CFG_MAX:
                c = '1;
            CFG_WIDE:
            begin
                c.work_seconds            = 16'($urandom);
                c.short_rest_seconds      = 16'($urandom);
                c.long_rest_seconds       = 16'($urandom);
                c.long_rest_every         = 8'($urandom);
                c.auto_pause_idle_seconds = 16'($urandom);
                c.auto_reset_idle_seconds = 16'($urandom);
                c.enable_bits             = 4'($urandom);
            end
            default:
            begin
                // short periods and low thresholds so ticks move the mode often
                c.work_seconds            = 16'($urandom_range(0, 12));
                c.short_rest_seconds      = 16'($urandom_range(0, 6));
                c.long_rest_seconds       = 16'($urandom_range(0, 8));
                c.long_rest_every         = 8'($urandom_range(0, 4));
                c.auto_pause_idle_seconds = 16'($urandom_range(1, 30));
                c.auto_reset_idle_seconds = 16'($urandom_range(1, 60));
                c.enable_bits             = 4'($urandom_range(0, 15));
            end
        endcase
        return c;
    endfunction

    // Idle values cluster at the thresholds, with extremes and full-range noise.
    function automatic logic [15:0] pick_idle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return tm_cfg.auto_pause_idle_seconds + 16'($urandom_range(0, 2)) - 16'd1;
            4, 5:    return tm_cfg.auto_reset_idle_seconds + 16'($urandom_range(0, 2)) - 16'd1;
            6, 7:    return 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wrct_item_t pick_item();
        int unsigned r;
        logic [3:0]  act;
        r = $urandom_range(0, 99);
        if (tm_mode inside {MODE_INIT, MODE_RESET, MODE_PAUSE} && r < 40)
            act = ACT_WORK;  // get out of the parked modes most of the time
        else if (r < 55)
            act = ACT_TICK;
        else if (r < 94)
            act = 4'($urandom_range(ACT_WORK, ACT_RESET));
        else
            act = 4'($urandom_range(ACT_RESET + 1, 15));
        return make_item(act, pick_idle(), $urandom_range(0, 2) == 0,
                         $urandom_range(0, 3) == 0);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every command, refused commands, unknown codes, fullscreen and idle pauses,
    // auto-reset, delay with an empty rest count.
    task automatic test_directed();
        wrct_cfg_t c;
        c.work_seconds            = 16'd3;
        c.short_rest_seconds      = 16'd2;
        c.long_rest_seconds       = 16'd2;
        c.long_rest_every         = 8'd1;
        c.auto_pause_idle_seconds = 16'd50;
        c.auto_reset_idle_seconds = 16'd100;
        c.enable_bits             = 4'hF;
        load_config(c);
        send_item(make_item(ACT_TICK,   16'd0, 1'b0, 1'b0));  // init ignores ticks
        send_item(make_item(ACT_PAUSE,  16'd0, 1'b0, 1'b0));  // refused
        send_item(make_item(ACT_RESUME, 16'd0, 1'b0, 1'b0));  // refused
        send_item(make_item(ACT_SKIP,   16'd0, 1'b0, 1'b0));  // refused outside work/rest
        send_item(make_item(ACT_RESET,  16'd0, 1'b0, 1'b0));  // refused
        send_item(make_item(4'd9,       16'd0, 1'b0, 1'b0));  // unknown
        send_item(make_item(4'd15,      16'hFFFF, 1'b1, 1'b1));  // unknown
        send_item(make_item(ACT_DELAY,  16'd0, 1'b0, 1'b0));  // keeps init, loads elapsed
        send_item(make_item(ACT_WORK,   16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_TICK,   16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_PAUSE,  16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_RESUME, 16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_TICK,   16'd0, 1'b1, 1'b1));  // fullscreen pause
        send_item(make_item(ACT_TICK,   16'd0, 1'b1, 1'b0));  // still fullscreen
        send_item(make_item(ACT_TICK,   16'd0, 1'b0, 1'b0));  // released without due
        send_item(make_item(ACT_TICK,   16'd50, 1'b0, 1'b0)); // idle pause
        send_item(make_item(ACT_TICK,   16'd100, 1'b0, 1'b0)); // auto-reset
        send_item(make_item(ACT_TICK,   16'd0, 1'b0, 1'b0));  // back to work
        repeat (3) send_item(make_item(ACT_TICK, 16'd0, 1'b0, 1'b0));  // into short rest
        send_item(make_item(ACT_DELAY,  16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_LONG,   16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_DELAY,  16'd0, 1'b0, 1'b0));  // rest count stays at zero
        send_item(make_item(ACT_SKIP,   16'd0, 1'b0, 1'b0));  // skip in work clears
        send_item(make_item(ACT_RESET,  16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_SHORT,  16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_SKIP,   16'd0, 1'b0, 1'b0));
        drain_results();
    endtask

    // Zero lengths: every tick ends a period, so the rest count climbs to saturate at 255.
    task automatic test_rest_count_saturation();
        wrct_cfg_t c;
        c = '0;
        load_config(c);
        idling = 1'b0;
        send_item(make_item(ACT_WORK, 16'd0, 1'b0, 1'b0));
        repeat (530) send_item(make_item(ACT_TICK, 16'd0, 1'b0, 1'b0));
        drain_results();
        idling = 1'b1;
    endtask

    // Long rest with long rests disabled never ends on a tick; elapsed keeps
    // counting until a command moves on.
    task automatic test_long_rest_held();
        wrct_cfg_t c;
        c = '0;
        load_config(c);
        idling = 1'b0;
        send_item(make_item(ACT_WORK, 16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_LONG, 16'd0, 1'b0, 1'b0));
        repeat (100) send_item(make_item(ACT_TICK, 16'd0, 1'b0, 1'b0));
        send_item(make_item(ACT_DELAY, 16'd0, 1'b0, 1'b0));
        drain_results();
        idling = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering: input must stall.
    task automatic test_backpressure();
        load_config(pick_config(CFG_SMALL));
        idling = 1'b0;
        sink_hold = HOLD_CYCLES;
        repeat (30) send_item(pick_item());
        drain_results();
        idling = 1'b1;
    endtask

    // Several register settings, extremes among them, each with random traffic.
    // Idling is switched on and off in stretches.
    task automatic test_random_phases();
        int kinds[7];
        kinds = '{CFG_SMALL, CFG_ZERO, CFG_SMALL, CFG_MAX, CFG_WIDE, CFG_SMALL, CFG_SMALL};
        foreach (kinds[p])
        begin
            load_config(pick_config(kinds[p]));
            for (int n = 0; n < RANDOM_PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    idling = ($urandom_range(0, 2) != 0);
                send_item(pick_item());
            end
            drain_results();
        end
        idling = 1'b1;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tm_cfg        = '0;
        tm_mode       = MODE_INIT;
        tm_elapsed    = '0;
        tm_rests      = '0;
        tm_reason     = REASON_NONE;
        error_count   = 0;
        idling        = 1'b1;
        sink_hold     = 0;
        sink_stall    = 0;
        quiet_cycles  = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_rest_count_saturation();
        test_long_rest_held();
        test_backpressure();
        test_random_phases();

        // every test drains; give stray beats a chance to show up
        drain_results();
        repeat (10) @(posedge clk);

        if (error_count == 0 && expected_status_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
